FILE: hw/rtl/frustum_cull_screen_projector_unit_defines.svh
// ----------------------------------------------------------------------------
// Frustum cull screen projector: assertion macros
// Concurrent checks on clk; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_SCREEN_PROJECTOR_UNIT_DEFINES_SVH
`define FRUSTUM_CULL_SCREEN_PROJECTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// check outside reset
`define FCSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds while reset is applied
`define FCSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCSP_ASSERT(lbl, prop, msg)
`define FCSP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/fcsp_pkg.sv
// ----------------------------------------------------------------------------
// Frustum cull screen projector package
// Shared widths, register indexes, request codes and reset values.
// ----------------------------------------------------------------------------
package fcsp_pkg;

  localparam int COORD_W         = 32;
  localparam int SCREEN_W        = 13;
  localparam int CFG_IDX_W       = 2;
  localparam int ENTRY_IDX_W     = 4;
  localparam int MAT_ENTRIES     = 16;
  localparam int Q_BITS          = 14;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_PLANE_TESTS = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 13'd800;
  localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 13'd600;

  // signed clip value width: product less fraction, plus headroom for sums
  function automatic int clip_width(input int frac);
    return 2 * COORD_W - frac + 3;
  endfunction

endpackage

FILE: hw/rtl/frustum_cull_screen_projector_unit.sv
// A point request passes the transform, viewport and divider stages, then the output register.
// Throughput: one request per cycle unless in_stall is high; the 12 matrix multiplies and the 14-stage
//   restoring divider are fully pipelined, so a point can enter every cycle that in_stall is low.
// Load requests produce no result.
// Reset (rst_n low, synchronous) empties the pipeline and sets the viewport to
//   800 x 600; matrix entries are undefined until loaded.
// ----------------------------------------------------------------------------
// Frustum cull screen projector
// Matrix transform, five-plane (six with PLANE_TESTS >= 6) visibility test and viewport mapping with
// round-half-up and saturation to the screen size.
// ----------------------------------------------------------------------------
`include "frustum_cull_screen_projector_unit_defines.svh"
module frustum_cull_screen_projector_unit
  import fcsp_pkg::*;
#(
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int PLANE_TESTS = DEF_PLANE_TESTS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SCREEN_W-1:0]       cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic [ENTRY_IDX_W-1:0]    in_entry_index,
  input  logic signed [COORD_W-1:0] in_entry_value,
  input  logic signed [COORD_W-1:0] in_world_x,
  input  logic signed [COORD_W-1:0] in_world_y,
  input  logic signed [COORD_W-1:0] in_world_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_visible,
  output logic [SCREEN_W-1:0]       out_screen_x,
  output logic [SCREEN_W-1:0]       out_screen_y
);

  localparam int CW = clip_width(FRAC_BITS);
  localparam int NW = CW + SCREEN_W + 1;

  logic [SCREEN_W-1:0] sw_r, sh_r;
  logic tf_rdy, vp_rdy, dv_rdy, en_o;
  logic clip_valid;
  logic signed [CW-1:0] clip_x, clip_y, clip_z, clip_w;
  logic vp_valid, vp_visible;
  logic [NW-1:0] vp_num_x, vp_num_y;
  logic [CW-1:0] vp_den;
  logic [SCREEN_W-1:0] vp_lim_x, vp_lim_y;
  logic dv_valid, dv_visible;
  logic [Q_BITS-1:0] dv_quo_x, dv_quo_y;
  logic [SCREEN_W-1:0] dv_lim_x, dv_lim_y;
  logic out_valid_r, out_visible_r;
  logic [SCREEN_W-1:0] out_screen_x_r, out_screen_y_r;
  logic [SCREEN_W-1:0] sx_nxt, sy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= RST_SCREEN_WIDTH;
      sh_r <= RST_SCREEN_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  sw_r <= cfg_data;
        REG_SCREEN_HEIGHT: sh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  fcsp_transform #(.FRAC_BITS(FRAC_BITS)) u_transform (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_world_x     (in_world_x),
    .in_world_y     (in_world_y),
    .in_world_z     (in_world_z),
    .dn_rdy         (vp_rdy),
    .up_rdy         (tf_rdy),
    .clip_valid     (clip_valid),
    .clip_x         (clip_x),
    .clip_y         (clip_y),
    .clip_z         (clip_z),
    .clip_w         (clip_w)
  );

  fcsp_viewport #(.FRAC_BITS(FRAC_BITS), .PLANE_TESTS(PLANE_TESTS)) u_viewport (
    .clk           (clk),
    .rst_n         (rst_n),
    .clip_valid    (clip_valid),
    .clip_x        (clip_x),
    .clip_y        (clip_y),
    .clip_z        (clip_z),
    .clip_w        (clip_w),
    .screen_width  (sw_r),
    .screen_height (sh_r),
    .dn_rdy        (dv_rdy),
    .up_rdy        (vp_rdy),
    .vp_valid      (vp_valid),
    .vp_visible    (vp_visible),
    .vp_num_x      (vp_num_x),
    .vp_num_y      (vp_num_y),
    .vp_den        (vp_den),
    .vp_lim_x      (vp_lim_x),
    .vp_lim_y      (vp_lim_y)
  );

  fcsp_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .vp_valid   (vp_valid),
    .vp_visible (vp_visible),
    .vp_num_x   (vp_num_x),
    .vp_num_y   (vp_num_y),
    .vp_den     (vp_den),
    .vp_lim_x   (vp_lim_x),
    .vp_lim_y   (vp_lim_y),
    .dn_rdy     (en_o),
    .up_rdy     (dv_rdy),
    .dv_valid   (dv_valid),
    .dv_visible (dv_visible),
    .dv_quo_x   (dv_quo_x),
    .dv_quo_y   (dv_quo_y),
    .dv_lim_x   (dv_lim_x),
    .dv_lim_y   (dv_lim_y)
  );

  // saturate to the screen; drop coordinates of culled points
  assign sx_nxt = !dv_visible ? '0 :
                  (dv_quo_x > Q_BITS'(dv_lim_x)) ? dv_lim_x : dv_quo_x[SCREEN_W-1:0];
  assign sy_nxt = !dv_visible ? '0 :
                  (dv_quo_y > Q_BITS'(dv_lim_y)) ? dv_lim_y : dv_quo_y[SCREEN_W-1:0];

  assign en_o = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_o) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_visible_r  <= dv_visible;
      out_screen_x_r <= sx_nxt;
      out_screen_y_r <= sy_nxt;
    end
  end

  assign in_stall     = !tf_rdy;
  assign out_valid    = out_valid_r;
  assign out_visible  = out_visible_r;
  assign out_screen_x = out_screen_x_r;
  assign out_screen_y = out_screen_y_r;

  `FCSP_ASSERT(a_culled_zero, out_valid_r && !out_visible_r |-> out_screen_x_r == '0 && out_screen_y_r == '0, "culled point has nonzero screen position")
  `FCSP_ASSERT(a_x_in_screen, out_valid_r && out_visible_r |-> out_screen_x_r <= sw_r, "screen x beyond viewport width")
  `FCSP_ASSERT(a_y_in_screen, out_valid_r && out_visible_r |-> out_screen_y_r <= sh_r, "screen y beyond viewport height")
  `FCSP_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r, "result valid straight after reset")

endmodule

FILE: hw/rtl/fcsp_transform.sv
// ----------------------------------------------------------------------------
// Clip transform
// Holds the matrix and turns a world point into clip x, y, z, w over four
// register stages: capture, multiply, partial sums, final sums.
// ----------------------------------------------------------------------------
module fcsp_transform
  import fcsp_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  localparam int CW = clip_width(FRAC_BITS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_action,
  input  logic [ENTRY_IDX_W-1:0]     in_entry_index,
  input  logic signed [COORD_W-1:0]  in_entry_value,
  input  logic signed [COORD_W-1:0]  in_world_x,
  input  logic signed [COORD_W-1:0]  in_world_y,
  input  logic signed [COORD_W-1:0]  in_world_z,
  input  logic                       dn_rdy,
  output logic                       up_rdy,
  output logic                       clip_valid,
  output logic signed [CW-1:0]       clip_x,
  output logic signed [CW-1:0]       clip_y,
  output logic signed [CW-1:0]       clip_z,
  output logic signed [CW-1:0]       clip_w
);

  logic signed [COORD_W-1:0]   mat_r [MAT_ENTRIES];
  logic signed [COORD_W-1:0]   wa_r [3];
  logic signed [2*COORD_W-1:0] prod_r [12];
  logic signed [COORD_W-1:0]   m3_r [4];
  logic signed [CW-1:0]        s01_r [4];
  logic signed [CW-1:0]        s23_r [4];
  logic signed [CW-1:0]        clip_r [4];
  logic va_r, vb_r, vc_r, vd_r;
  logic en_a, en_b, en_c, en_d;
  logic take;

  assign en_d = !vd_r || dn_rdy;
  assign en_c = !vc_r || en_d;
  assign en_b = !vb_r || en_c;
  assign en_a = !va_r || en_b;
  assign up_rdy = en_a;
  assign take = in_valid && en_a;

  always_ff @(posedge clk) begin
    if (take && in_action == ACT_LOAD) begin
      mat_r[in_entry_index] <= in_entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid && in_action == ACT_POINT;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
      if (en_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      wa_r[0] <= in_world_x;
      wa_r[1] <= in_world_y;
      wa_r[2] <= in_world_z;
    end
    // matrix is read here; a later load only lands after this point moved on
    if (en_b) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_r[i*4+j] <= wa_r[i] * mat_r[i*4+j];
        end
      end
      for (int j = 0; j < 4; j++) begin
        m3_r[j] <= mat_r[12+j];
      end
    end
    if (en_c) begin
      for (int j = 0; j < 4; j++) begin
        s01_r[j] <= CW'(prod_r[j] >>> FRAC_BITS) + CW'(prod_r[4+j] >>> FRAC_BITS);
        s23_r[j] <= CW'(prod_r[8+j] >>> FRAC_BITS) + CW'(m3_r[j]);
      end
    end
    if (en_d) begin
      for (int j = 0; j < 4; j++) begin
        clip_r[j] <= s01_r[j] + s23_r[j];
      end
    end
  end

  assign clip_valid = vd_r;
  assign clip_x = clip_r[0];
  assign clip_y = clip_r[1];
  assign clip_z = clip_r[2];
  assign clip_w = clip_r[3];

endmodule

FILE: hw/rtl/fcsp_viewport.sv
// ----------------------------------------------------------------------------
// Viewport setup
// Plane tests, then scaled numerators s*a + cw and the divisor 2*cw over
// three register stages.
// ----------------------------------------------------------------------------
module fcsp_viewport
  import fcsp_pkg::*;
#(
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int PLANE_TESTS = DEF_PLANE_TESTS,
  localparam int CW = clip_width(FRAC_BITS),
  localparam int NW = CW + SCREEN_W + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clip_valid,
  input  logic signed [CW-1:0] clip_x,
  input  logic signed [CW-1:0] clip_y,
  input  logic signed [CW-1:0] clip_z,
  input  logic signed [CW-1:0] clip_w,
  input  logic [SCREEN_W-1:0]  screen_width,
  input  logic [SCREEN_W-1:0]  screen_height,
  input  logic                 dn_rdy,
  output logic                 up_rdy,
  output logic                 vp_valid,
  output logic                 vp_visible,
  output logic [NW-1:0]        vp_num_x,
  output logic [NW-1:0]        vp_num_y,
  output logic [CW-1:0]        vp_den,
  output logic [SCREEN_W-1:0]  vp_lim_x,
  output logic [SCREEN_W-1:0]  vp_lim_y
);

  localparam int HW = CW - COORD_W;

  logic signed [CW-1:0] px, mx, py, my, mz;
  logic vis_c;
  logic ve_r, vf_r, vg_r;
  logic en_e, en_f, en_g;
  logic vis_e_r, vis_f_r, vis_g_r;
  logic [CW-1:0] ax_e_r, ay_e_r, cw_e_r, cw_f_r, den_g_r;
  logic [SCREEN_W-1:0] sw_e_r, sh_e_r, sw_f_r, sh_f_r, sw_g_r, sh_g_r;
  logic [COORD_W+SCREEN_W-1:0] lox_f_r, loy_f_r;
  logic [HW+SCREEN_W-1:0] hix_f_r, hiy_f_r;
  logic [NW-1:0] nx_g_r, ny_g_r;

  assign px = clip_w + clip_x;
  assign mx = clip_w - clip_x;
  assign py = clip_w + clip_y;
  assign my = clip_w - clip_y;
  assign mz = clip_w - clip_z;
  assign vis_c = (clip_w != '0) && !px[CW-1] && !mx[CW-1] && !py[CW-1] &&
                 !my[CW-1] && !clip_z[CW-1] && (PLANE_TESTS < 6 || !mz[CW-1]);

  assign en_g = !vg_r || dn_rdy;
  assign en_f = !vf_r || en_g;
  assign en_e = !ve_r || en_f;
  assign up_rdy = en_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
    end else begin
      if (en_e) ve_r <= clip_valid;
      if (en_f) vf_r <= ve_r;
      if (en_g) vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      vis_e_r <= vis_c;
      ax_e_r  <= px;
      ay_e_r  <= my;
      cw_e_r  <= clip_w;
      sw_e_r  <= screen_width;
      sh_e_r  <= screen_height;
    end
    // split the wide operand so each multiply has a factor of at most 32 bits
    if (en_f) begin
      vis_f_r <= vis_e_r;
      lox_f_r <= sw_e_r * ax_e_r[COORD_W-1:0];
      hix_f_r <= sw_e_r * ax_e_r[CW-1:COORD_W];
      loy_f_r <= sh_e_r * ay_e_r[COORD_W-1:0];
      hiy_f_r <= sh_e_r * ay_e_r[CW-1:COORD_W];
      cw_f_r  <= cw_e_r;
      sw_f_r  <= sw_e_r;
      sh_f_r  <= sh_e_r;
    end
    if (en_g) begin
      vis_g_r <= vis_f_r;
      nx_g_r  <= (NW'(hix_f_r) << COORD_W) + NW'(lox_f_r) + NW'(cw_f_r);
      ny_g_r  <= (NW'(hiy_f_r) << COORD_W) + NW'(loy_f_r) + NW'(cw_f_r);
      den_g_r <= {cw_f_r[CW-2:0], 1'b0};
      sw_g_r  <= sw_f_r;
      sh_g_r  <= sh_f_r;
    end
  end

  assign vp_valid   = vg_r;
  assign vp_visible = vis_g_r;
  assign vp_num_x   = nx_g_r;
  assign vp_num_y   = ny_g_r;
  assign vp_den     = den_g_r;
  assign vp_lim_x   = sw_g_r;
  assign vp_lim_y   = sh_g_r;

endmodule

FILE: hw/rtl/fcsp_divider.sv
// ----------------------------------------------------------------------------
// Screen divider
// Restoring division of both numerators by 2*cw, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fcsp_divider
  import fcsp_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  localparam int CW = clip_width(FRAC_BITS),
  localparam int NW = CW + SCREEN_W + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vp_valid,
  input  logic                vp_visible,
  input  logic [NW-1:0]       vp_num_x,
  input  logic [NW-1:0]       vp_num_y,
  input  logic [CW-1:0]       vp_den,
  input  logic [SCREEN_W-1:0] vp_lim_x,
  input  logic [SCREEN_W-1:0] vp_lim_y,
  input  logic                dn_rdy,
  output logic                up_rdy,
  output logic                dv_valid,
  output logic                dv_visible,
  output logic [Q_BITS-1:0]   dv_quo_x,
  output logic [Q_BITS-1:0]   dv_quo_y,
  output logic [SCREEN_W-1:0] dv_lim_x,
  output logic [SCREEN_W-1:0] dv_lim_y
);

  logic                v_r   [Q_BITS];
  logic                vis_r [Q_BITS];
  logic [NW-1:0]       rx_r  [Q_BITS];
  logic [NW-1:0]       ry_r  [Q_BITS];
  logic [CW-1:0]       d_r   [Q_BITS];
  logic [Q_BITS-1:0]   qx_r  [Q_BITS];
  logic [Q_BITS-1:0]   qy_r  [Q_BITS];
  logic [SCREEN_W-1:0] lx_r  [Q_BITS];
  logic [SCREEN_W-1:0] ly_r  [Q_BITS];
  logic                en    [Q_BITS];

  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    localparam int B = Q_BITS - 1 - k;
    logic                vp, visp;
    logic [NW-1:0]       rxp, ryp, dsh;
    logic [CW-1:0]       dp;
    logic [Q_BITS-1:0]   qxp, qyp;
    logic [SCREEN_W-1:0] lxp, lyp;
    logic                gex, gey;

    if (k == 0) begin : g_head
      assign vp   = vp_valid;
      assign visp = vp_visible;
      assign rxp  = vp_num_x;
      assign ryp  = vp_num_y;
      assign dp   = vp_den;
      assign qxp  = '0;
      assign qyp  = '0;
      assign lxp  = vp_lim_x;
      assign lyp  = vp_lim_y;
    end else begin : g_body
      assign vp   = v_r[k-1];
      assign visp = vis_r[k-1];
      assign rxp  = rx_r[k-1];
      assign ryp  = ry_r[k-1];
      assign dp   = d_r[k-1];
      assign qxp  = qx_r[k-1];
      assign qyp  = qy_r[k-1];
      assign lxp  = lx_r[k-1];
      assign lyp  = ly_r[k-1];
    end

    if (k == Q_BITS - 1) begin : g_last
      assign en[k] = !v_r[k] || dn_rdy;
    end else begin : g_mid
      assign en[k] = !v_r[k] || en[k+1];
    end

    assign dsh = NW'(dp) << B;
    assign gex = rxp >= dsh;
    assign gey = ryp >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        vis_r[k] <= visp;
        rx_r[k]  <= gex ? rxp - dsh : rxp;
        ry_r[k]  <= gey ? ryp - dsh : ryp;
        d_r[k]   <= dp;
        qx_r[k]  <= qxp | (Q_BITS'(gex) << B);
        qy_r[k]  <= qyp | (Q_BITS'(gey) << B);
        lx_r[k]  <= lxp;
        ly_r[k]  <= lyp;
      end
    end
  end

  assign up_rdy     = en[0];
  assign dv_valid   = v_r[Q_BITS-1];
  assign dv_visible = vis_r[Q_BITS-1];
  assign dv_quo_x   = qx_r[Q_BITS-1];
  assign dv_quo_y   = qy_r[Q_BITS-1];
  assign dv_lim_x   = lx_r[Q_BITS-1];
  assign dv_lim_y   = ly_r[Q_BITS-1];

endmodule
